/* design/hsvn_pkg.sv */
// Shared constants, types and a helper function for the hashed value-noise block.
package hsvn_pkg;

    localparam int LIMB_W     = 32;
    localparam int HASH_W     = 64;
    localparam int UNIT_W     = 53;
    localparam int DIFF_W     = UNIT_W + 1;
    localparam int HASH_DROP  = 11;
    localparam int NUM_STAGES = 22;

    localparam logic [HASH_W-1:0] GOLDEN       = 64'h9e3779b97f4a7c15;
    localparam logic [HASH_W-1:0] MIX_C1       = 64'hbf58476d1ce4e5b9;
    localparam logic [HASH_W-1:0] MIX_C2       = 64'h94d049bb133111eb;
    localparam logic [HASH_W-1:0] FRAME_K      = 64'h517cc1b727220a95;
    localparam logic [HASH_W-1:0] INDEX_K      = 64'h6eed0e9da4d94a4f;
    localparam logic [HASH_W-1:0] INDEX_OFFSET = 64'd4099;

    localparam int SHIFT_A = 30;
    localparam int SHIFT_B = 27;
    localparam int SHIFT_C = 31;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;
    typedef logic [HASH_W-1:0]     hash_t;

    // last xor-shift of the finaliser
    function automatic hash_t mix_fin(input hash_t p);
        return p ^ (p >> SHIFT_C);
    endfunction

endpackage

/* design/hsvn_mul.sv */
// Two-stage multiplier: 32x32 partial products, then a registered sum.
module hsvn_mul #(
    parameter int A_W = 64,
    parameter int B_W = 64,
    parameter int P_W = 64
) (
    input  logic           aclk,
    input  logic           en_pp,
    input  logic           en_sum,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic [P_W-1:0] p
);

    localparam int LW     = hsvn_pkg::LIMB_W;
    localparam int NA     = (A_W + LW - 1) / LW;
    localparam int NB     = (B_W + LW - 1) / LW;
    localparam int FULL_W = (NA + NB) * LW;

    logic [NA*LW-1:0] a_pad;
    logic [NB*LW-1:0] b_pad;
    logic [2*LW-1:0]  pp_reg [NA*NB];
    logic [FULL_W-1:0] acc;
    logic [P_W-1:0]   p_reg;

    assign a_pad = (NA*LW)'(a);
    assign b_pad = (NB*LW)'(b);

    always_ff @(posedge aclk) begin
        if (en_pp) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i*NB+j] <= a_pad[i*LW +: LW] * b_pad[j*LW +: LW];
                end
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (FULL_W'(pp_reg[i*NB+j]) << (LW * (i + j)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_sum) begin
            p_reg <= acc[P_W-1:0];
        end
    end

    assign p = p_reg;

endmodule

/* design/hsvn_delay.sv */
// Pipeline delay line whose taps advance with their own stage enables.
module hsvn_delay #(
    parameter int W = 64,
    parameter int N = 2
) (
    input  logic         aclk,
    input  logic [N-1:0] en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [N];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            sr_reg[0] <= d;
        end
        for (int k = 1; k < N; k++) begin
            if (en[k]) begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign q = sr_reg[N-1];

endmodule

/* design/hsvn_mix.sv */
// Splitmix64 finaliser lane up to the second product: six pipeline stages.
module hsvn_mix (
    input  logic                aclk,
    input  logic [5:0]          en,
    input  hsvn_pkg::hash_t     v,
    output hsvn_pkg::hash_t     p
);

    hsvn_pkg::hash_t t;
    hsvn_pkg::hash_t u_reg;
    hsvn_pkg::hash_t p1;
    hsvn_pkg::hash_t w_reg;

    assign t = v + hsvn_pkg::GOLDEN;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            u_reg <= t ^ (t >> hsvn_pkg::SHIFT_A);
        end
        if (en[3]) begin
            w_reg <= p1 ^ (p1 >> hsvn_pkg::SHIFT_B);
        end
    end

    hsvn_mul #(.A_W(hsvn_pkg::HASH_W), .B_W(hsvn_pkg::HASH_W), .P_W(hsvn_pkg::HASH_W)) u_mul1 (
        .aclk   (aclk),
        .en_pp  (en[1]),
        .en_sum (en[2]),
        .a      (u_reg),
        .b      (hsvn_pkg::MIX_C1),
        .p      (p1)
    );

    hsvn_mul #(.A_W(hsvn_pkg::HASH_W), .B_W(hsvn_pkg::HASH_W), .P_W(hsvn_pkg::HASH_W)) u_mul2 (
        .aclk   (aclk),
        .en_pp  (en[4]),
        .en_sum (en[5]),
        .a      (w_reg),
        .b      (hsvn_pkg::MIX_C2),
        .p      (p)
    );

endmodule

/* design/hsvn_ctrl.sv */
// Valid bits of every pipeline stage and the per-stage advance enables.
module hsvn_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hsvn_pkg::stage_vec_t en
);

    localparam int NS = hsvn_pkg::NUM_STAGES;

    hsvn_pkg::stage_vec_t valid_reg;
    hsvn_pkg::stage_vec_t valid_next;

    // a stage may load when the receiver is ready or some stage at or after it is empty
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            en[k] = m_ready || ((valid_reg >> k) != ({NS{1'b1}} >> k));
        end
    end

    always_comb begin
        valid_next = valid_reg;
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                valid_next[k] = (k == 0) ? s_valid : valid_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[NS-1];

endmodule

/* design/hashed_smooth_value_noise.sv */
// Top level of the hashed 1-D value-noise pipeline.
//
// Input channel s_*: coordinate (Q47.16, signed), frame number and channel word.
// Output channel m_*: smoothstep-blended noise in signed Q1.OUT and unit Q0.OUT
// form, plus the exact lattice value at the floor index in Q1.52 and Q0.53.
// cfg_we/cfg_wdata write the 64-bit noise seed; write it only while no beat is
// in flight.
//
// One beat is accepted per cycle while s_ready is high. The pipeline depth is
// set by the five chained 64-bit products of the hash (two stages each) plus
// the interpolation product. Apart from the seed, the block holds no state
// between beats.
//
// Reset clears all stage valid bits and sets the seed to zero; there is no
// clearing pass. When the receiver stalls, the output register holds and
// earlier stages keep filling until every stage is full; only then does
// s_ready drop.
module hashed_smooth_value_noise #(
    parameter int COORD_FRACTION_BITS  = 16,
    parameter int OUTPUT_FRACTION_BITS = 32
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_we,
    input  logic [63:0]                                cfg_wdata,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic signed [63:0]                         s_coordinate,
    input  logic signed [31:0]                         s_frame_number,
    input  logic [63:0]                                s_channel_word,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic signed [OUTPUT_FRACTION_BITS:0]       m_smooth_signed,
    output logic [OUTPUT_FRACTION_BITS-1:0]            m_smooth_unit,
    output logic signed [hsvn_pkg::UNIT_W-1:0]         m_lattice_signed,
    output logic [hsvn_pkg::UNIT_W-1:0]                m_lattice_unit
);

    localparam int OUTF = OUTPUT_FRACTION_BITS;
    localparam int UW   = hsvn_pkg::UNIT_W;
    localparam int DW   = hsvn_pkg::DIFF_W;
    localparam int HW   = hsvn_pkg::HASH_W;
    localparam int PW   = DW + OUTF;

    hsvn_pkg::stage_vec_t en_w;

    logic [63:0] noise_seed_reg;

    // stage 0 capture
    hsvn_pkg::hash_t af_reg, ai0_reg, ai1_reg, chan_reg;
    hsvn_pkg::hash_t idx;
    logic [COORD_FRACTION_BITS-1:0] x;
    logic [OUTF-1:0]   f_next, f_reg;
    logic [OUTF+1:0]   g_reg;

    hsvn_pkg::hash_t mf, mi0, mi1, pf, pi0, pi1, chan_d;
    hsvn_pkg::hash_t comb0_reg, comb1_reg, q0, q1;
    hsvn_pkg::hash_t h0, h1;
    logic [UW-1:0]     ua0_reg, ua1_reg, ua0_d;
    logic [DW-1:0]     diff_reg;

    logic [2*OUTF-1:0] sq_full, bl_full;
    logic [OUTF+1:0]   g_d;
    logic [OUTF-1:0]   blend_d;
    logic [OUTF:0]     bs_d;
    logic [PW-1:0]     prod, corr;
    logic signed [PW-1:0] prod_s;
    logic signed [DW-1:0] term_reg;
    logic signed [DW-1:0] a_ext, sum;

    logic signed [OUTF:0]     smooth_signed_reg;
    logic [OUTF-1:0]          smooth_unit_reg;
    logic signed [UW-1:0]     lattice_signed_reg;
    logic [UW-1:0]            lattice_unit_reg;

    hsvn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .en      (en_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_seed_reg <= '0;
        end else if (cfg_we) begin
            noise_seed_reg <= cfg_wdata;
        end
    end

    assign idx = HW'(s_coordinate >>> COORD_FRACTION_BITS);
    assign x   = s_coordinate[COORD_FRACTION_BITS-1:0];

    if (OUTF >= COORD_FRACTION_BITS) begin : g_f_up
        assign f_next = OUTF'(x) << (OUTF - COORD_FRACTION_BITS);
    end else begin : g_f_down
        assign f_next = OUTF'(x >> (COORD_FRACTION_BITS - OUTF));
    end

    // stage 0: offsets and the blend operands
    always_ff @(posedge aclk) begin
        if (en_w[0]) begin
            af_reg   <= HW'(s_frame_number) + HW'(1);
            ai0_reg  <= idx + hsvn_pkg::INDEX_OFFSET;
            ai1_reg  <= idx + hsvn_pkg::INDEX_OFFSET + HW'(1);
            chan_reg <= s_channel_word;
            f_reg    <= f_next;
            g_reg    <= ((OUTF+2)'(3) << OUTF) - {1'b0, f_next, 1'b0};
        end
    end

    // stages 1-2: lane scrambling products
    hsvn_mul #(.A_W(HW), .B_W(HW), .P_W(HW)) u_mul_f (
        .aclk(aclk), .en_pp(en_w[1]), .en_sum(en_w[2]),
        .a(af_reg), .b(hsvn_pkg::FRAME_K), .p(mf)
    );
    hsvn_mul #(.A_W(HW), .B_W(HW), .P_W(HW)) u_mul_i0 (
        .aclk(aclk), .en_pp(en_w[1]), .en_sum(en_w[2]),
        .a(ai0_reg), .b(hsvn_pkg::INDEX_K), .p(mi0)
    );
    hsvn_mul #(.A_W(HW), .B_W(HW), .P_W(HW)) u_mul_i1 (
        .aclk(aclk), .en_pp(en_w[1]), .en_sum(en_w[2]),
        .a(ai1_reg), .b(hsvn_pkg::INDEX_K), .p(mi1)
    );

    // stages 3-8: first finaliser pass on each lane
    hsvn_mix u_mix_f  (.aclk(aclk), .en(en_w[8:3]), .v(mf),  .p(pf));
    hsvn_mix u_mix_i0 (.aclk(aclk), .en(en_w[8:3]), .v(mi0), .p(pi0));
    hsvn_mix u_mix_i1 (.aclk(aclk), .en(en_w[8:3]), .v(mi1), .p(pi1));

    hsvn_delay #(.W(HW), .N(8)) u_dly_chan (
        .aclk(aclk), .en(en_w[8:1]), .d(chan_reg), .q(chan_d)
    );

    // stage 9: fold seed, frame, index and channel
    always_ff @(posedge aclk) begin
        if (en_w[9]) begin
            comb0_reg <= noise_seed_reg ^ chan_d ^ hsvn_pkg::mix_fin(pf)
                         ^ hsvn_pkg::mix_fin(pi0);
            comb1_reg <= noise_seed_reg ^ chan_d ^ hsvn_pkg::mix_fin(pf)
                         ^ hsvn_pkg::mix_fin(pi1);
        end
    end

    // stages 10-15: final finaliser pass
    hsvn_mix u_mix_h0 (.aclk(aclk), .en(en_w[15:10]), .v(comb0_reg), .p(q0));
    hsvn_mix u_mix_h1 (.aclk(aclk), .en(en_w[15:10]), .v(comb1_reg), .p(q1));

    assign h0 = hsvn_pkg::mix_fin(q0);
    assign h1 = hsvn_pkg::mix_fin(q1);

    // stage 16: unit lattice values; stage 17: b - a
    always_ff @(posedge aclk) begin
        if (en_w[16]) begin
            ua0_reg <= h0[HW-1:hsvn_pkg::HASH_DROP];
            ua1_reg <= h1[HW-1:hsvn_pkg::HASH_DROP];
        end
        if (en_w[17]) begin
            diff_reg <= {1'b0, ua1_reg} - {1'b0, ua0_reg};
        end
    end

    // blend weight: stages 1-4
    hsvn_mul #(.A_W(OUTF), .B_W(OUTF), .P_W(2*OUTF)) u_mul_sq (
        .aclk(aclk), .en_pp(en_w[1]), .en_sum(en_w[2]),
        .a(f_reg), .b(f_reg), .p(sq_full)
    );
    hsvn_delay #(.W(OUTF+2), .N(2)) u_dly_g (
        .aclk(aclk), .en(en_w[2:1]), .d(g_reg), .q(g_d)
    );
    // smoothstep stays below one, so the top product bits are always zero
    hsvn_mul #(.A_W(OUTF), .B_W(OUTF+2), .P_W(2*OUTF)) u_mul_bl (
        .aclk(aclk), .en_pp(en_w[3]), .en_sum(en_w[4]),
        .a(sq_full[2*OUTF-1:OUTF]), .b(g_d), .p(bl_full)
    );
    hsvn_delay #(.W(OUTF), .N(13)) u_dly_bl (
        .aclk(aclk), .en(en_w[17:5]), .d(bl_full[2*OUTF-1:OUTF]), .q(blend_d)
    );

    // stages 18-19: (b - a) * blend, taken unsigned and corrected for the sign
    hsvn_mul #(.A_W(DW), .B_W(OUTF), .P_W(PW)) u_mul_lerp (
        .aclk(aclk), .en_pp(en_w[18]), .en_sum(en_w[19]),
        .a(diff_reg), .b(blend_d), .p(prod)
    );
    hsvn_delay #(.W(OUTF+1), .N(2)) u_dly_bs (
        .aclk(aclk), .en(en_w[19:18]), .d({diff_reg[DW-1], blend_d}), .q(bs_d)
    );
    hsvn_delay #(.W(UW), .N(4)) u_dly_ua (
        .aclk(aclk), .en(en_w[20:17]), .d(ua0_reg), .q(ua0_d)
    );

    assign corr   = bs_d[OUTF] ? (PW'(bs_d[OUTF-1:0]) << DW) : '0;
    assign prod_s = signed'(prod - corr);

    // stage 20: arithmetic shift rounds toward minus infinity
    always_ff @(posedge aclk) begin
        if (en_w[20]) begin
            term_reg <= DW'(prod_s >>> OUTF);
        end
    end

    // a = ua - 2^52 is ua with its top bit flipped
    assign a_ext = {~ua0_d[UW-1], ~ua0_d[UW-1], ua0_d[UW-2:0]};
    assign sum   = a_ext + term_reg;

    // stage 21: output register
    always_ff @(posedge aclk) begin
        if (en_w[21]) begin
            smooth_signed_reg  <= sum[UW-1:UW-1-OUTF];
            smooth_unit_reg    <= {~sum[UW-1], sum[UW-2:UW-OUTF]};
            lattice_signed_reg <= {~ua0_d[UW-1], ua0_d[UW-2:0]};
            lattice_unit_reg   <= ua0_d;
        end
    end

    assign m_smooth_signed  = smooth_signed_reg;
    assign m_smooth_unit    = smooth_unit_reg;
    assign m_lattice_signed = lattice_signed_reg;
    assign m_lattice_unit   = lattice_unit_reg;

`ifndef SYNTHESIS
    // an empty or draining output stage never blocks the input
    a_ready_when_draining: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("s_ready low while the output stage can move");

    // both lattice forms come from the same hash
    a_lattice_forms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lattice_signed == {~m_lattice_unit[UW-1], m_lattice_unit[UW-2:0]}))
        else $error("lattice signed and unit values disagree");

    // the top bit of the unit blend is the inverse of the signed blend's sign bit
    a_smooth_forms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_smooth_unit[OUTF-1] == ~m_smooth_signed[OUTF]))
        else $error("smooth unit and signed values disagree in sign");
`endif

endmodule

/* sim/hashed_smooth_value_noise_check.sv */
`timescale 1ns / 1ps
// Checker for the hashed value-noise block: predicts every result beat and compares it.
module hashed_smooth_value_noise_check #(
    parameter int OUT_FRAC = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [63:0]                       cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [63:0]                       s_coordinate,
    input  logic [31:0]                       s_frame_number,
    input  logic [63:0]                       s_channel_word,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [OUT_FRAC:0]                 m_smooth_signed,
    input  logic [OUT_FRAC-1:0]               m_smooth_unit,
    input  logic [hsvn_pkg::UNIT_W-1:0]       m_lattice_signed,
    input  logic [hsvn_pkg::UNIT_W-1:0]       m_lattice_unit,
    output int unsigned                       n_errors,
    output int unsigned                       outstanding
);

    localparam int COORD_FRAC  = 16;
    localparam int MAX_REPORTS = 10;

    localparam logic [63:0] SM_GAMMA   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL_1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL_2   = 64'h94d049bb133111eb;
    localparam logic [63:0] FRAME_MUL  = 64'h517cc1b727220a95;
    localparam logic [63:0] CELL_MUL   = 64'h6eed0e9da4d94a4f;
    localparam logic [63:0] CELL_BIAS  = 64'd4099;
    localparam logic [63:0] HALF_UNIT  = 64'h0010_0000_0000_0000;
    localparam logic [63:0] UNIT_MASK  = 64'h001f_ffff_ffff_ffff;

    typedef struct packed {
        logic [63:0]          coordinate;
        logic [OUT_FRAC:0]    smooth_signed;
        logic [OUT_FRAC-1:0]  smooth_unit;
        logic [52:0]          lattice_signed;
        logic [52:0]          lattice_unit;
    } noise_beat_t;

    noise_beat_t  noise_due [$];
    noise_beat_t  want;
    logic [63:0]  seed_copy;
    int unsigned  fault_count;

    assign n_errors = fault_count;

    function automatic logic [63:0] finalise64(input logic [63:0] v);
        logic [63:0] z;
        z = v + SM_GAMMA;
        z = (z ^ (z >> 30)) * SM_MUL_1;
        z = (z ^ (z >> 27)) * SM_MUL_2;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [63:0] lattice_hash(input logic [63:0] lat_idx,
                                                 input logic [63:0] frame,
                                                 input logic [63:0] chan, input logic [63:0] seed);
        logic [63:0] v;
        v = seed ^ finalise64((frame + 64'd1) * FRAME_MUL)
                 ^ finalise64((lat_idx + CELL_BIAS) * CELL_MUL) ^ chan;
        return finalise64(v);
    endfunction

    function automatic noise_beat_t predict_noise(input logic [63:0] coord,
                                                  input logic [31:0] frame,
                                                  input logic [63:0] chan,
                                                  input logic [63:0] seed);
        logic [63:0]         lat_idx, frame_ext, ua, ub, a, b, f, sq, blend, diff, sum, scaled;
        logic [127:0]        wide;
        logic signed [127:0] swide;
        noise_beat_t         r;
        lat_idx   = $signed(coord) >>> COORD_FRAC;
        frame_ext = {{32{frame[31]}}, frame};
        ua        = lattice_hash(lat_idx, frame_ext, chan, seed) >> 11;
        ub        = lattice_hash(lat_idx + 64'd1, frame_ext, chan, seed) >> 11;
        a         = ua - HALF_UNIT;
        b         = ub - HALF_UNIT;
        f         = {48'b0, coord[COORD_FRAC-1:0]} << (OUT_FRAC - COORD_FRAC);
        // smoothstep: f^2 (3 - 2f), each product truncated
        wide  = {64'b0, f} * {64'b0, f};
        wide  = wide >> OUT_FRAC;
        sq    = wide[63:0];
        wide  = {64'b0, sq} * {64'b0, (64'd3 << OUT_FRAC) - (f << 1)};
        wide  = wide >> OUT_FRAC;
        blend = wide[63:0];
        // signed step times blend, floored
        diff  = b - a;
        swide = $signed({{64{diff[63]}}, diff}) * $signed({64'b0, blend});
        swide = swide >>> OUT_FRAC;
        sum   = a + swide[63:0];
        scaled = $signed(sum) >>> (52 - OUT_FRAC);
        r.smooth_signed  = scaled[OUT_FRAC:0];
        scaled = ((sum + HALF_UNIT) & UNIT_MASK) >> (53 - OUT_FRAC);
        r.smooth_unit    = scaled[OUT_FRAC-1:0];
        r.lattice_signed = a[52:0];
        r.lattice_unit   = ua[52:0];
        r.coordinate     = coord;
        return r;
    endfunction

    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string field, input logic [63:0] coord,
                               input logic [63:0] want_v, input logic [63:0] got_v);
        if (got_v !== want_v)
            log_fault($sformatf("%s at coordinate %h: expected %h, got %h",
                                field, coord, want_v, got_v));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_copy = '0;
            noise_due.delete();
        end else begin
            if (s_valid && s_ready)
                noise_due.push_back(predict_noise(s_coordinate, s_frame_number,
                                                  s_channel_word, seed_copy));
            if (m_valid && m_ready) begin
                if (noise_due.size() == 0) begin
                    log_fault($sformatf("result beat with none due, lattice_unit %h",
                                        m_lattice_unit));
                end else begin
                    want = noise_due.pop_front();
                    check_field("smooth_signed", want.coordinate, want.smooth_signed,
                                m_smooth_signed);
                    check_field("smooth_unit", want.coordinate, want.smooth_unit,
                                m_smooth_unit);
                    check_field("lattice_signed", want.coordinate, want.lattice_signed,
                                m_lattice_signed);
                    check_field("lattice_unit", want.coordinate, want.lattice_unit,
                                m_lattice_unit);
                end
            end
            if (cfg_we)
                seed_copy = cfg_wdata;
        end
        outstanding <= noise_due.size();
    end

endmodule

/* sim/hashed_smooth_value_noise_test.sv */
`timescale 1ns / 1ps
// Top of the hashed value-noise testbench: clock, reset, stimulus and verdict.
module hashed_smooth_value_noise_test;

    localparam int OUT_FRAC       = 32;
    localparam int PHASE_ITEMS    = 110;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 40;
    localparam int IDLE_PERCENT   = 34;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_we;
    logic [63:0]                  cfg_wdata;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [63:0]           s_coordinate;
    logic signed [31:0]           s_frame_number;
    logic [63:0]                  s_channel_word;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [OUT_FRAC:0]     m_smooth_signed;
    logic [OUT_FRAC-1:0]          m_smooth_unit;
    logic signed [hsvn_pkg::UNIT_W-1:0] m_lattice_signed;
    logic [hsvn_pkg::UNIT_W-1:0]  m_lattice_unit;

    int unsigned                  n_errors;
    int unsigned                  outstanding;
    logic                         calm;
    logic [63:0]                  walk_coord;

    hashed_smooth_value_noise i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_coordinate     (s_coordinate),
        .s_frame_number   (s_frame_number),
        .s_channel_word   (s_channel_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_smooth_signed  (m_smooth_signed),
        .m_smooth_unit    (m_smooth_unit),
        .m_lattice_signed (m_lattice_signed),
        .m_lattice_unit   (m_lattice_unit)
    );

    hashed_smooth_value_noise_check #(.OUT_FRAC(OUT_FRAC)) i_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_coordinate     (s_coordinate),
        .s_frame_number   (s_frame_number),
        .s_channel_word   (s_channel_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_smooth_signed  (m_smooth_signed),
        .m_smooth_unit    (m_smooth_unit),
        .m_lattice_signed (m_lattice_signed),
        .m_lattice_unit   (m_lattice_unit),
        .n_errors         (n_errors),
        .outstanding      (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("hashed_smooth_value_noise_test NOT OK");
        $finish;
    end

    // Receiver: random back-pressure, plus a long hold every so often so the pipe fills
    initial begin
        int unsigned taken;
        taken   = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                taken++;
                if (taken % 200 == 120) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    task automatic send_beat(input logic [63:0] coord, input logic [31:0] frame,
                             input logic [63:0] chan);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_coordinate   <= coord;
        s_frame_number <= frame;
        s_channel_word <= chan;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random_beat();
        logic [63:0] coord;
        logic [31:0] frame;
        logic [63:0] chan;
        case ($urandom_range(0, 3))
            0: coord = {$urandom, $urandom};
            // a few cells either side of the origin
            1: coord = ((64'($urandom_range(0, 16)) - 64'd8) << 16)
                       | 64'($urandom_range(0, 65535));
            // walk along the line, as a renderer would
            2: begin
                walk_coord = walk_coord + 64'($urandom_range(1, 20000));
                coord = walk_coord;
            end
            default: begin
                coord = {$urandom, $urandom};
                case ($urandom_range(0, 4))
                    0: coord[15:0] = 16'h0000;
                    1: coord[15:0] = 16'h0001;
                    2: coord[15:0] = 16'h7fff;
                    3: coord[15:0] = 16'h8000;
                    default: coord[15:0] = 16'hffff;
                endcase
            end
        endcase
        frame = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 4)) - 32'd2;
        chan  = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 3));
        send_beat(coord, frame, chan);
    endtask

    // seed may only change with the pipe empty
    task automatic load_seed(input logic [63:0] seed);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [63:0] seeds [5];
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_coordinate   = '0;
        s_frame_number = '0;
        s_channel_word = '0;
        calm           = 1'b0;
        walk_coord     = {$urandom, $urandom};
        seeds[0] = 64'hffff_ffff_ffff_ffff;
        seeds[1] = 64'h0;
        seeds[2] = {$urandom, $urandom};
        seeds[3] = 64'h8000_0000_0000_0001;
        seeds[4] = {$urandom, $urandom};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed beats under the reset seed
        send_beat(64'h0, 32'h0, 64'h0);
        send_beat(64'h8000_0000_0000_0000, 32'h8000_0000, 64'h0);
        send_beat(64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff, 64'hffff_ffff_ffff_ffff);
        send_beat(64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 64'h0);
        send_beat(64'h8000_0000_0000_ffff, 32'h0000_0001, 64'h1);
        send_beat(64'h7fff_ffff_ffff_0000, 32'hffff_fffe, 64'h8000_0000_0000_0000);
        send_beat(64'h0000_0000_0000_0001, 32'h0, 64'h1);
        send_beat(64'h0000_0000_0000_8000, 32'h0, 64'h1);
        send_beat(64'h0000_0000_0000_ffff, 32'h0, 64'h1);
        send_beat(64'h0000_0000_0001_0000, 32'h0, 64'h0);
        send_beat(64'hffff_ffff_ffff_0000, 32'h0, 64'h0);
        send_beat(64'hffff_ffff_ffff_8000, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
        // lattice cells where the biased index or its successor is zero
        send_beat(64'hffff_ffff_effd_0000, 32'h0, 64'h0);
        send_beat(64'hffff_ffff_effc_8000, 32'h0, 64'h0);
        // sweep across one cell
        send_beat(64'h0000_0000_0005_0000, 32'h7, 64'hffff_ffff_ffff_ffff);
        send_beat(64'h0000_0000_0005_4000, 32'h7, 64'hffff_ffff_ffff_ffff);
        send_beat(64'h0000_0000_0005_8000, 32'h7, 64'hffff_ffff_ffff_ffff);
        send_beat(64'h0000_0000_0005_c000, 32'h7, 64'hffff_ffff_ffff_ffff);
        send_beat(64'h0000_0000_0005_ffff, 32'h7, 64'hffff_ffff_ffff_ffff);
        send_beat(64'h0000_0000_0006_0000, 32'h7, 64'hffff_ffff_ffff_ffff);

        for (int phase = 0; phase < 5; phase++) begin
            load_seed(seeds[phase]);
            calm = (phase == 2);
            repeat (PHASE_ITEMS) send_random_beat();
        end
        calm = 1'b0;

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_errors == 0 && outstanding == 0)
            $display("hashed_smooth_value_noise_test OK");
        else
            $display("hashed_smooth_value_noise_test NOT OK");
        $finish;
    end

endmodule
